>>> rtl/core/ffaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_pkg: shared types and constants
// Command and status codes and sizing defaults.
// ----------------------------------------------------------------------------
package ffaa_pkg;

  localparam int unsigned MaxArenaBytesDef = 16384;
  localparam int unsigned PageBytesDef     = 4096;
  localparam int unsigned HeaderBytesDef   = 32;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_UNINIT  = 2'd2,
    ST_NO_MEM  = 2'd3
  } status_e;

endpackage

>>> rtl/core/ffaa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaa_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ffaa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/core/first_fit_arena_allocator.sv
`timescale 1ns / 1ps
// Sequence: destroy and early argument errors go straight to done_o; init writes
//   one header; alloc walks headers, then reports no fit or takes the fit, split
//   when room remains; free walks to its header, then rejects or frees it with merges.
// Throughput: one transaction at a time; busy stays high through the done_o cycle.
//   All steps share the one header memory port (one access per cycle).
// Reset: arena not live; header memory is not cleared, only reachable headers are read.
// ----------------------------------------------------------------------------
// first_fit_arena_allocator: first-fit allocator with split and coalesce
// Walks an address-ordered, doubly linked header list held in one RAM.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator #(
  parameter int unsigned MaxArenaBytes = ffaa_pkg::MaxArenaBytesDef,
  parameter int unsigned PageBytes     = ffaa_pkg::PageBytesDef,
  parameter int unsigned HeaderBytes   = ffaa_pkg::HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [14:0] length_i,
  input  logic [13:0] payload_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [13:0] result_offset_o,
  output logic [14:0] arena_bytes_o
);

  localparam int unsigned AW = $clog2(MaxArenaBytes);
  // header: size, free, fwd_ok, fwd, bwd_ok, bwd
  localparam int unsigned SW = AW + 1;
  localparam int unsigned HW = SW + 1 + 2 * (AW + 1);
  localparam int unsigned PW = $clog2(PageBytes);

  typedef struct packed {
    logic [SW-1:0] size;
    logic          free;
    logic          fok;
    logic [AW-1:0] fwd;
    logic          bok;
    logic [AW-1:0] bwd;
  } hdr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_WAIT, S_EVAL,
    S_SPL_N, S_SPL_RF, S_SPL_WF0, S_SPL_WF1, S_SPL_C,
    S_FR_RN, S_FR_WN, S_FR_EN, S_FR_RNN, S_FR_WNN0, S_FR_WNN1,
    S_FR_WC, S_FR_RP, S_FR_WP0, S_FR_WP1, S_FR_RF, S_FR_WF0, S_FR_WF1,
    S_DONE
  } state_e;

  state_e        state_q;
  logic          live_q;
  logic [1:0]    cmd_q;
  logic [SW-1:0] len_q;
  logic [AW-1:0] tgt_q, cur_q, aux_q;
  logic [SW:0]   walk_q;
  hdr_t          c_q, n_q;
  logic [1:0]    status_q;
  logic [13:0]   roff_q;
  logic [14:0]   bytes_q;

  logic          we;
  logic [AW-1:0] addr;
  hdr_t          wdata, rdata;

  ffaa_ram #(.Width(HW), .Depth(MaxArenaBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // init size rounding
  logic [15:0] len16, adj;
  logic        init_bad;
  assign len16 = {1'b0, length_i};
  assign adj   = ((len16 + 16'(PageBytes - 1)) >> PW) << PW;
  assign init_bad = (length_i == '0) || (32'(length_i) > MaxArenaBytes) ||
                    (32'(adj) > MaxArenaBytes) || (32'(adj) < HeaderBytes);

  // split arithmetic, computed combinationally
  logic [AW+1:0] nw_sum;
  logic [SW:0]   len_hdr;
  assign len_hdr = {1'b0, len_q} + (SW+1)'(HeaderBytes);
  assign nw_sum  = (AW+2)'(cur_q) + (AW+2)'(len_hdr);

  logic [SW:0] merge_sum;
  assign merge_sum = {1'b0, c_q.size} + (SW+1)'(HeaderBytes) + {1'b0, rdata.size};

  // memory port mux; walk and next-neighbor reads hold their address through a wait state
  always_comb begin
    we    = 1'b0;
    addr  = cur_q;
    wdata = c_q;
    case (state_q)
      S_SPL_N: begin
        we = 1'b1; addr = aux_q; wdata = n_q;
      end
      S_SPL_RF, S_SPL_WF0, S_FR_RNN, S_FR_WNN0, S_FR_RF, S_FR_WF0: addr = c_q.fwd;
      S_SPL_WF1, S_FR_WNN1, S_FR_WF1: begin
        we = 1'b1; addr = c_q.fwd; wdata = rdata;
        wdata.bok = 1'b1; wdata.bwd = aux_q;
      end
      S_SPL_C, S_FR_WC: begin
        we = 1'b1; addr = cur_q;
      end
      S_FR_RN, S_FR_WN: addr = c_q.fwd;
      S_FR_RP: addr = c_q.bwd;
      S_FR_WP1: begin
        we = 1'b1; addr = c_q.bwd; wdata = n_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      live_q   <= 1'b0;
      status_q <= ffaa_pkg::ST_OK;
      roff_q   <= '0;
      bytes_q  <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      tgt_q    <= '0;
      cur_q    <= '0;
      aux_q    <= '0;
      walk_q   <= '0;
      c_q      <= '0;
      n_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (start) begin
          cmd_q    <= cmd_i;
          len_q    <= SW'(length_i);
          cur_q    <= '0;
          walk_q   <= '0;
          status_q <= ffaa_pkg::ST_OK;
          roff_q   <= '0;
          bytes_q  <= '0;
          state_q  <= S_DONE;
          case (ffaa_pkg::cmd_e'(cmd_i))
            ffaa_pkg::CMD_INIT: begin
              if (init_bad) begin
                status_q <= ffaa_pkg::ST_BAD_ARG;
              end else begin
                live_q  <= 1'b1;
                bytes_q <= adj[14:0];
                c_q     <= '{size: SW'(adj - 16'(HeaderBytes)), free: 1'b1,
                             fok: 1'b0, fwd: '0, bok: 1'b0, bwd: '0};
                state_q <= S_SPL_C;
              end
            end
            ffaa_pkg::CMD_ALLOC: begin
              if (!live_q) status_q <= ffaa_pkg::ST_UNINIT;
              else if (length_i == '0) status_q <= ffaa_pkg::ST_BAD_ARG;
              else state_q <= S_RD;
            end
            ffaa_pkg::CMD_FREE: begin
              if (payload_offset_i == '0) status_q <= ffaa_pkg::ST_BAD_ARG;
              else if (!live_q) status_q <= ffaa_pkg::ST_UNINIT;
              else if (32'(payload_offset_i) < HeaderBytes ||
                       32'(payload_offset_i) - HeaderBytes >= MaxArenaBytes)
                status_q <= ffaa_pkg::ST_BAD_ARG;
              else begin
                tgt_q   <= AW'(32'(payload_offset_i) - HeaderBytes);
                state_q <= S_RD;
              end
            end
            default: begin
              if (!live_q) status_q <= ffaa_pkg::ST_UNINIT;
              else live_q <= 1'b0;
            end
          endcase
        end
        S_RD:   state_q <= S_WAIT;
        S_WAIT: state_q <= S_EVAL;
        S_EVAL: begin
          walk_q <= walk_q + 1'b1;
          if (cmd_q == ffaa_pkg::CMD_ALLOC) begin
            if (rdata.free && rdata.size >= len_q) begin
              roff_q <= 14'(32'(cur_q) + HeaderBytes);
              aux_q  <= nw_sum[AW-1:0];
              if ({1'b0, rdata.size} > len_hdr && nw_sum < (AW+2)'(MaxArenaBytes)) begin
                c_q <= rdata;
                n_q <= '{size: SW'({1'b0, rdata.size} - len_hdr), free: 1'b1,
                         fok: rdata.fok, fwd: rdata.fwd, bok: 1'b1, bwd: cur_q};
                state_q <= S_SPL_N;
              end else begin
                c_q     <= '{size: rdata.size, free: 1'b0, fok: rdata.fok,
                             fwd: rdata.fwd, bok: rdata.bok, bwd: rdata.bwd};
                state_q <= S_SPL_C;
              end
            end else if (!rdata.fok || rdata.fwd <= cur_q ||
                         32'(walk_q) + 1 >= MaxArenaBytes) begin
              status_q <= ffaa_pkg::ST_NO_MEM;
              state_q  <= S_DONE;
            end else begin
              cur_q   <= rdata.fwd;
              state_q <= S_RD;
            end
          end else begin
            if (cur_q == tgt_q) begin
              if (rdata.free) begin
                status_q <= ffaa_pkg::ST_BAD_ARG;
                state_q  <= S_DONE;
              end else begin
                c_q     <= '{size: rdata.size, free: 1'b1, fok: rdata.fok,
                             fwd: rdata.fwd, bok: rdata.bok, bwd: rdata.bwd};
                state_q <= (rdata.fok) ? S_FR_RN : S_FR_WC;
              end
            end else if (!rdata.fok || rdata.fwd <= cur_q ||
                         32'(walk_q) + 1 >= MaxArenaBytes) begin
              status_q <= ffaa_pkg::ST_BAD_ARG;
              state_q  <= S_DONE;
            end else begin
              cur_q   <= rdata.fwd;
              state_q <= S_RD;
            end
          end
        end
        // split: new header, then back link of old next, then current
        S_SPL_N: begin
          c_q.size <= len_q;
          c_q.free <= 1'b0;
          if (c_q.fok) begin
            state_q <= S_SPL_RF;
          end else begin
            c_q.fok <= 1'b1;
            c_q.fwd <= aux_q;
            state_q <= S_SPL_C;
          end
        end
        S_SPL_RF:  state_q <= S_SPL_WF0;
        S_SPL_WF0: state_q <= S_SPL_WF1;
        S_SPL_WF1: begin
          c_q.fok <= 1'b1;
          c_q.fwd <= aux_q;
          state_q <= S_SPL_C;
        end
        S_SPL_C: state_q <= S_DONE;
        // free: next neighbor merge
        S_FR_RN: state_q <= S_FR_WN;
        S_FR_WN: state_q <= S_FR_EN;
        S_FR_EN: begin
          if (rdata.free) begin
            c_q.size <= merge_sum[SW-1:0];
            c_q.fok  <= rdata.fok;
            c_q.fwd  <= rdata.fwd;
            aux_q    <= cur_q;
            state_q  <= rdata.fok ? S_FR_RNN : S_FR_WC;
          end else begin
            state_q <= S_FR_WC;
          end
        end
        S_FR_RNN:  state_q <= S_FR_WNN0;
        S_FR_WNN0: state_q <= S_FR_WNN1;
        S_FR_WNN1: state_q <= S_FR_WC;
        S_FR_WC:   state_q <= c_q.bok ? S_FR_RP : S_DONE;
        // free: previous neighbor merge
        S_FR_RP:  state_q <= S_FR_WP0;
        S_FR_WP0: begin
          if (rdata.free) begin
            n_q     <= '{size: SW'({1'b0, rdata.size} + (SW+1)'(HeaderBytes) +
                                   {1'b0, c_q.size}),
                         free: rdata.free, fok: c_q.fok, fwd: c_q.fwd,
                         bok: rdata.bok, bwd: rdata.bwd};
            aux_q   <= c_q.bwd;
            state_q <= S_FR_WP1;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FR_WP1: state_q <= c_q.fok ? S_FR_RF : S_DONE;
        S_FR_RF:  state_q <= S_FR_WF0;
        S_FR_WF0: state_q <= S_FR_WF1;
        S_FR_WF1: state_q <= S_DONE;
        S_DONE:   state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign status_o        = done_o ? status_q : 2'd0;
  assign result_offset_o = done_o ? roff_q : '0;
  assign arena_bytes_o   = done_o ? bytes_q : '0;

  // checks
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_no_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o || $past(state_q) == S_IDLE) else $error("early done");
  a_off_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_offset_o != '0) |-> status_o == ffaa_pkg::ST_OK)
    else $error("offset with error");
  a_bytes_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && arena_bytes_o != '0) |-> live_q) else $error("bytes without arena");

endmodule
